>>> hdl/lspc_pkg.sv
package lspc_pkg;

	localparam int unsigned PATTERN_COUNT_DEF = 6;

	// configuration port
	localparam int unsigned CFG_DATA_W = 20;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THERM_LIM  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOW_LVL   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FAST_LVL   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_LVL = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_LVL = 3'd5;

	// request codes
	typedef enum logic [2:0] {
		CMD_TICK       = 3'd0,
		CMD_ALERT      = 3'd1,
		CMD_STROBE     = 3'd2,
		CMD_EMERGENCY  = 3'd3,
		CMD_DEACTIVATE = 3'd4,
		CMD_SET_PAT    = 3'd5,
		CMD_ENABLE     = 3'd6,
		CMD_DISABLE    = 3'd7
	} cmd_t;

	// pattern codes
	localparam logic [2:0] PAT_OFF    = 3'd0;
	localparam logic [2:0] PAT_SLOW   = 3'd1;
	localparam logic [2:0] PAT_FAST   = 3'd2;
	localparam logic [2:0] PAT_DOUBLE = 3'd3;
	localparam logic [2:0] PAT_RANDOM = 3'd4;
	localparam logic [2:0] PAT_EMERG  = 3'd5;

	// mode codes
	localparam logic [1:0] MODE_OFF    = 2'd0;
	localparam logic [1:0] MODE_WARN   = 2'd1;
	localparam logic [1:0] MODE_FLASH  = 2'd2;
	localparam logic [1:0] MODE_EMERG  = 2'd3;

	// timing and thermal constants
	localparam logic [31:0] THERM_PERIOD = 32'd1000;
	localparam logic [31:0] RAMP_PERIOD  = 32'd10;
	localparam logic [7:0]  RAMP_STEP    = 8'd5;
	localparam logic [7:0]  HOT_LEVEL    = 8'd50;
	localparam logic [19:0] TEMP_BASE    = 20'd25000;
	localparam logic [19:0] TEMP_MAX     = 20'd1048575;
	localparam logic [19:0] TEMP_COOL    = 20'd100;
	localparam logic [19:0] THERM_HYST   = 20'd10000;

	// floor(p/510) by reciprocal: q0 = (p*M510) >> 37 is q or q-1
	localparam int unsigned HEAT_W      = 29;
	localparam logic [28:0] M510        = 29'd269488144;
	localparam int unsigned M510_SHIFT  = 37;
	localparam logic [9:0]  DIV510      = 10'd510;
	// heat product at or above this saturates the temperature
	localparam logic [39:0] HEAT_SAT    = 40'd522023760;

	typedef enum logic [1:0] {
		SH38,
		SH40,
		SH42
	} sh_t;

	typedef struct packed {
		logic [10:0] d;
		logic [31:0] m;
		sh_t         sh;
	} div_t;

	typedef struct packed {
		cmd_t        kind;
		logic [31:0] now_ms;
		logic [2:0]  sel;
		logic        sel_ok;
		logic [2:0]  rbits;
	} item_t;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QUEUE_AW    = 1;

	// period and reciprocal for the elapsed-time modulo of each pattern
	function automatic div_t pat_div(input logic [2:0] pat);
		div_t r;
		case (pat)
			PAT_SLOW:   r = '{d: 11'd2000, m: 32'd2199023255, sh: SH42};
			PAT_FAST:   r = '{d: 11'd400,  m: 32'd2748779069, sh: SH40};
			PAT_DOUBLE: r = '{d: 11'd1400, m: 32'd3141461793, sh: SH42};
			PAT_RANDOM: r = '{d: 11'd300,  m: 32'd3665038759, sh: SH40};
			default:    r = '{d: 11'd100,  m: 32'd2748779069, sh: SH38};
		endcase
		return r;
	endfunction

endpackage

>>> hdl/lspc_front.sv
module lspc_front #(
	parameter int unsigned PATTERN_COUNT = lspc_pkg::PATTERN_COUNT_DEF
) (
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          req_type,
	input  logic [31:0]         now_ms,
	input  logic [2:0]          pattern_sel,
	input  logic [2:0]          random_bits,
	input  logic                q_full,
	output logic                q_push,
	output lspc_pkg::item_t     q_item
);
	import lspc_pkg::*;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	// decode the request and settle pattern legality up front
	always_comb begin
		q_item.kind   = cmd_t'(req_type);
		q_item.now_ms = now_ms;
		q_item.sel    = pattern_sel;
		q_item.sel_ok = ({1'b0, pattern_sel} < 4'(PATTERN_COUNT));
		q_item.rbits  = random_bits;
	end

endmodule

>>> hdl/lspc_queue.sv
module lspc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lspc_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            nonempty,
	output lspc_pkg::item_t head
);
	import lspc_pkg::*;

	item_t                 mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_AW:0]     cnt_q;

	assign full     = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/lspc_back.sv
module lspc_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lspc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lspc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            q_nonempty,
	input  lspc_pkg::item_t                 q_head,
	output logic                            q_pop,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [7:0]                      led0_drive,
	output logic [7:0]                      led1_drive,
	output logic                            thermal_active,
	output logic [1:0]                      mode_now,
	output logic                            enabled_now
);
	import lspc_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_EXEC = 6'b000010,
		ST_MUL  = 6'b000100,
		ST_QD   = 6'b001000,
		ST_FIX  = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t        state_q;
	item_t         itm_q;

	// configuration
	logic [7:0]    amb_q;
	logic [19:0]   tlim_q;
	logic [7:0]    lvl_slow_q;
	logic [7:0]    lvl_fast_q;
	logic [7:0]    lvl_dbl_q;
	logic [7:0]    lvl_rnd_q;

	// architectural state
	logic [1:0]    mode_q;
	logic [2:0]    pat_q;
	logic [31:0]   pstart_q;
	logic          en_q;
	logic          prot_q;
	logic [31:0]   therm_t_q;
	logic [7:0]    lvl_q       [2];
	logic [7:0]    tgt_q       [2];
	logic [31:0]   ramp_t_q    [2];
	logic          lit_q       [2];
	logic [31:0]   lit_since_q [2];
	logic [19:0]   temp_q      [2];
	logic [7:0]    drv_q       [2];

	// sequenced datapath
	logic          ramped_q    [2];
	logic          hot_q       [2];
	logic          sat_q       [2];
	logic [39:0]   ph_q        [2];
	logic [16:0]   pd_q        [2];
	logic [20:0]   hq0_q       [2];
	logic [8:0]    dq0_q       [2];
	logic [28:0]   hq_q        [2];
	logic [16:0]   dq_q        [2];
	logic [31:0]   el_q;
	logic [25:0]   pq0_q;
	logic [31:0]   pqd_q;

	// output register
	logic          out_valid_q;
	logic [7:0]    o_drv0_q;
	logic [7:0]    o_drv1_q;
	logic          o_prot_q;
	logic [1:0]    o_mode_q;
	logic          o_en_q;

	logic          out_free;
	logic          is_tick;
	logic [31:0]   now;
	div_t          dv;

	// thermal check
	logic          tdue;
	logic [19:0]   tmax;
	logic          t_over;
	logic          t_rel;
	logic          therm_clr;
	logic          prot_tick;

	// ramp
	logic [7:0]    tgt_eff  [2];
	logic          rdue     [2];
	logic          up       [2];
	logic [7:0]    diff     [2];
	logic [7:0]    cur_n    [2];
	logic [31:0]   lit_dt   [2];
	logic [39:0]   ph_n     [2];
	logic [16:0]   pd_n     [2];
	logic [31:0]   el_n;
	logic [63:0]   pm_n;
	logic [25:0]   pq0_n;

	// divide stages
	logic [57:0]   hm_n     [2];
	logic [45:0]   dm_n     [2];
	logic [30:0]   hq_n     [2];
	logic [18:0]   dq_n     [2];
	logic [36:0]   pqd_n;
	logic [28:0]   hr       [2];
	logic [16:0]   dr       [2];
	logic [20:0]   hq_fin   [2];
	logic [8:0]    dq_fin   [2];
	logic [19:0]   heat     [2];
	logic [19:0]   cool     [2];

	// pattern
	logic [31:0]   r0;
	logic [10:0]   pos;
	logic          pat_apply;
	logic          pat_set;
	logic [7:0]    pat_t0;
	logic [7:0]    pat_t1;

	assign now      = itm_q.now_ms;
	assign is_tick  = (itm_q.kind == CMD_TICK);
	assign dv       = pat_div(pat_q);
	assign out_free = !out_valid_q || out_ready;
	assign q_pop    = q_nonempty && ((state_q == ST_IDLE) || ((state_q == ST_DONE) && out_free));

	// thermal check against both channels
	always_comb begin
		tdue      = ((now - therm_t_q) > THERM_PERIOD);
		tmax      = (temp_q[0] > temp_q[1]) ? temp_q[0] : temp_q[1];
		t_over    = (tmax > tlim_q);
		t_rel     = (tlim_q >= THERM_HYST) && (tmax < (tlim_q - THERM_HYST));
		therm_clr = tdue && t_over && !prot_q;
		prot_tick = prot_q;
		if (tdue && t_over) begin
			prot_tick = 1'b1;
		end else if (tdue && t_rel) begin
			prot_tick = 1'b0;
		end
	end

	// ramp step and product setup per channel
	always_comb begin
		for (int c = 0; c < 2; c++) begin
			tgt_eff[c] = therm_clr ? 8'd0 : tgt_q[c];
			rdue[c]    = (lvl_q[c] != tgt_eff[c]) && ((now - ramp_t_q[c]) > RAMP_PERIOD);
			up[c]      = (tgt_eff[c] > lvl_q[c]);
			diff[c]    = up[c] ? (tgt_eff[c] - lvl_q[c]) : (lvl_q[c] - tgt_eff[c]);
			if (!rdue[c]) begin
				cur_n[c] = lvl_q[c];
			end else if (diff[c] < RAMP_STEP) begin
				cur_n[c] = tgt_eff[c];
			end else if (up[c]) begin
				cur_n[c] = lvl_q[c] + RAMP_STEP;
			end else begin
				cur_n[c] = lvl_q[c] - RAMP_STEP;
			end
			lit_dt[c] = lit_q[c] ? (now - lit_since_q[c]) : 32'd0;
			ph_n[c]   = 40'(cur_n[c]) * 40'(lit_dt[c]);
			pd_n[c]   = 17'(cur_n[c]) * 17'(9'd255 + 9'(amb_q));
		end
	end

	// elapsed time against the pattern period, wrapping at 32 bits
	always_comb begin
		el_n = now - pstart_q;
		pm_n = 64'(el_n) * 64'(dv.m);
		case (dv.sh)
			SH38:    pq0_n = pm_n[63:38];
			SH40:    pq0_n = {2'b0, pm_n[63:40]};
			SH42:    pq0_n = {4'b0, pm_n[63:42]};
			default: pq0_n = pm_n[63:38];
		endcase
	end

	// reciprocal divide by 510 and its correction
	always_comb begin
		for (int c = 0; c < 2; c++) begin
			hm_n[c]   = 58'(ph_q[c][HEAT_W-1:0]) * 58'(M510);
			dm_n[c]   = 46'(pd_q[c]) * 46'(M510);
			hq_n[c]   = 31'(hq0_q[c]) * 31'(DIV510);
			dq_n[c]   = 19'(dq0_q[c]) * 19'(DIV510);
			hr[c]     = ph_q[c][HEAT_W-1:0] - hq_q[c];
			dr[c]     = pd_q[c] - dq_q[c];
			hq_fin[c] = (hr[c] >= 29'(DIV510)) ? (hq0_q[c] + 21'd1) : hq0_q[c];
			dq_fin[c] = (dr[c] >= 17'(DIV510)) ? (dq0_q[c] + 9'd1) : dq0_q[c];
			heat[c]   = sat_q[c] ? TEMP_MAX : (hq_fin[c][19:0] + TEMP_BASE);
			cool[c]   = (temp_q[c] >= (TEMP_BASE + TEMP_COOL)) ? (temp_q[c] - TEMP_COOL)
			                                                  : TEMP_BASE;
		end
		pqd_n = 37'(pq0_q) * 37'(dv.d);
	end

	// pattern targets
	always_comb begin
		r0        = el_q - pqd_q;
		pos       = (r0 >= 32'(dv.d)) ? 11'(r0 - 32'(dv.d)) : r0[10:0];
		pat_apply = (mode_q != MODE_OFF) && !prot_q;
		pat_set   = 1'b0;
		pat_t0    = 8'd0;
		pat_t1    = 8'd0;
		case (pat_q)
			PAT_OFF: begin
				pat_set = 1'b1;
			end
			PAT_SLOW: begin
				pat_set = 1'b1;
				pat_t0  = (pos < 11'd500) ? lvl_slow_q : 8'd0;
				pat_t1  = pat_t0;
			end
			PAT_FAST: begin
				pat_set = 1'b1;
				pat_t0  = (pos < 11'd200) ? lvl_fast_q : 8'd0;
				pat_t1  = pat_t0;
			end
			PAT_DOUBLE: begin
				pat_set = 1'b1;
				pat_t0  = ((pos < 11'd100) || ((pos >= 11'd200) && (pos < 11'd300)))
				          ? lvl_dbl_q : 8'd0;
				pat_t1  = pat_t0;
			end
			PAT_RANDOM: begin
				// random bits pick the channel and both on/off states
				pat_set = (pos == 11'd0);
				if (itm_q.rbits[1]) begin
					pat_t1 = itm_q.rbits[0] ? lvl_rnd_q : 8'd0;
					pat_t0 = itm_q.rbits[2] ? lvl_rnd_q : 8'd0;
				end else begin
					pat_t0 = itm_q.rbits[0] ? lvl_rnd_q : 8'd0;
					pat_t1 = itm_q.rbits[2] ? lvl_rnd_q : 8'd0;
				end
			end
			PAT_EMERG: begin
				pat_set = 1'b1;
				pat_t0  = (pos < 11'd50) ? 8'd255 : 8'd0;
				pat_t1  = (pos < 11'd50) ? 8'd0 : 8'd255;
			end
			default: begin
				pat_set = 1'b0;
			end
		endcase
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		if (q_pop) begin
			itm_q <= q_head;
		end
		if (state_q == ST_EXEC) begin
			el_q  <= el_n;
			pq0_q <= pq0_n;
			for (int c = 0; c < 2; c++) begin
				ph_q[c]  <= ph_n[c];
				pd_q[c]  <= pd_n[c];
				hot_q[c] <= (cur_n[c] > HOT_LEVEL);
			end
		end
		if (state_q == ST_MUL) begin
			pqd_q <= pqd_n[31:0];
			for (int c = 0; c < 2; c++) begin
				sat_q[c] <= (ph_q[c] >= HEAT_SAT);
				hq0_q[c] <= hm_n[c][57:M510_SHIFT];
				dq0_q[c] <= dm_n[c][45:M510_SHIFT];
			end
		end
		if (state_q == ST_QD) begin
			for (int c = 0; c < 2; c++) begin
				hq_q[c] <= hq_n[c][28:0];
				dq_q[c] <= dq_n[c][16:0];
			end
		end
		if ((state_q == ST_DONE) && out_free) begin
			o_drv0_q <= drv_q[0];
			o_drv1_q <= drv_q[1];
			o_prot_q <= prot_q;
			o_mode_q <= mode_q;
			o_en_q   <= en_q;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amb_q      <= 8'd0;
			tlim_q     <= 20'd60000;
			lvl_slow_q <= 8'd128;
			lvl_fast_q <= 8'd255;
			lvl_dbl_q  <= 8'd255;
			lvl_rnd_q  <= 8'd255;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_AMBIENT:    amb_q      <= cfg_data[7:0];
				CFG_THERM_LIM:  tlim_q     <= cfg_data;
				CFG_SLOW_LVL:   lvl_slow_q <= cfg_data[7:0];
				CFG_FAST_LVL:   lvl_fast_q <= cfg_data[7:0];
				CFG_DOUBLE_LVL: lvl_dbl_q  <= cfg_data[7:0];
				CFG_RANDOM_LVL: lvl_rnd_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// sequencer and block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			mode_q      <= MODE_OFF;
			pat_q       <= PAT_OFF;
			pstart_q    <= '0;
			en_q        <= 1'b1;
			prot_q      <= 1'b0;
			therm_t_q   <= '0;
			for (int c = 0; c < 2; c++) begin
				lvl_q[c]       <= '0;
				tgt_q[c]       <= '0;
				ramp_t_q[c]    <= '0;
				lit_q[c]       <= 1'b0;
				lit_since_q[c] <= '0;
				temp_q[c]      <= TEMP_BASE;
				drv_q[c]       <= '0;
				ramped_q[c]    <= 1'b0;
			end
		end else begin
			// raise valid with a new result, drop it once taken
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= (is_tick && en_q) ? ST_MUL : ST_DONE;
					case (itm_q.kind)
						CMD_TICK: begin
							if (en_q) begin
								prot_q  <= prot_tick;
								if (tdue) begin
									therm_t_q <= now;
								end
								for (int c = 0; c < 2; c++) begin
									tgt_q[c]    <= tgt_eff[c];
									lvl_q[c]    <= cur_n[c];
									ramped_q[c] <= rdue[c];
									if (rdue[c]) begin
										ramp_t_q[c] <= now;
									end
									if (cur_n[c] > HOT_LEVEL) begin
										if (!lit_q[c]) begin
											lit_q[c]       <= 1'b1;
											lit_since_q[c] <= now;
										end
									end else begin
										lit_q[c] <= 1'b0;
									end
								end
							end
						end
						CMD_ALERT, CMD_STROBE: begin
							if (en_q && !prot_q) begin
								mode_q   <= itm_q.kind[1:0];
								pat_q    <= itm_q.kind;
								pstart_q <= now;
							end
						end
						CMD_EMERGENCY: begin
							mode_q   <= MODE_EMERG;
							pat_q    <= PAT_EMERG;
							pstart_q <= now;
							prot_q   <= 1'b0;
						end
						CMD_DEACTIVATE: begin
							mode_q   <= MODE_OFF;
							pat_q    <= PAT_OFF;
							tgt_q[0] <= '0;
							tgt_q[1] <= '0;
						end
						CMD_SET_PAT: begin
							if (itm_q.sel_ok) begin
								pat_q    <= itm_q.sel;
								pstart_q <= now;
							end
						end
						CMD_ENABLE: begin
							en_q <= 1'b1;
						end
						CMD_DISABLE: begin
							en_q     <= 1'b0;
							mode_q   <= MODE_OFF;
							pat_q    <= PAT_OFF;
							tgt_q[0] <= '0;
							tgt_q[1] <= '0;
						end
						default: ;
					endcase
				end
				ST_MUL: begin
					state_q <= ST_QD;
				end
				ST_QD: begin
					state_q <= ST_FIX;
					if (pat_apply && pat_set) begin
						tgt_q[0] <= pat_t0;
						tgt_q[1] <= pat_t1;
					end
				end
				ST_FIX: begin
					state_q <= ST_DONE;
					for (int c = 0; c < 2; c++) begin
						temp_q[c] <= hot_q[c] ? heat[c] : cool[c];
						if (ramped_q[c]) begin
							drv_q[c] <= dq_fin[c][7:0];
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= q_pop ? ST_EXEC : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign led0_drive     = o_drv0_q;
	assign led1_drive     = o_drv1_q;
	assign thermal_active = o_prot_q;
	assign mode_now       = o_mode_q;
	assign enabled_now    = o_en_q;

endmodule

>>> hdl/led_strobe_pattern_controller_unit.sv
// Two-channel LED strobe pattern controller.
//
// Input channel (in_valid/in_ready): one request per handshake, either a
// millisecond tick (now_ms, random_bits) or a command (alert, strobe,
// emergency, deactivate, set pattern, enable, disable).
// Output channel (out_valid/out_ready): exactly one result per request,
// in order: both PWM drive values, thermal protection, mode and enable.
// Configuration: write cfg_data to register cfg_index while cfg_we is high;
// only write while no request is in flight.
//
// The back-end sequencer works on one request at a time: a tick passes
// through ramp, reciprocal multiply, product, correction and result, a
// command straight from execution to its result. A 2-entry request queue
// sits between the accept stage and the sequencer, so in_ready stays high
// while earlier requests are worked on, until the queue is full.
// When the receiver stalls, the result holds in the output register, the
// sequencer waits, and requests keep filling the queue until it is full.
// Reset (arst_n low) clears the sequencer and block state: enabled, mode off,
// pattern off, levels zero, temperatures at 25000 mdeg, configuration to its defaults.
module led_strobe_pattern_controller_unit #(
	parameter int unsigned PATTERN_COUNT = lspc_pkg::PATTERN_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [2:0]                      req_type,
	input  logic [31:0]                     now_ms,
	input  logic [2:0]                      pattern_sel,
	input  logic [2:0]                      random_bits,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [7:0]                      led0_drive,
	output logic [7:0]                      led1_drive,
	output logic                            thermal_active,
	output logic [1:0]                      mode_now,
	output logic                            enabled_now,
	input  logic                            cfg_we,
	input  logic [lspc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lspc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lspc_pkg::*;

	logic  q_full;
	logic  q_push;
	logic  q_pop;
	logic  q_nonempty;
	item_t q_in;
	item_t q_head;

	// accept and classify each request
	lspc_front #(
		.PATTERN_COUNT(PATTERN_COUNT)
	) u_front (
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.now_ms      (now_ms),
		.pattern_sel (pattern_sel),
		.random_bits (random_bits),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_item      (q_in)
	);

	// hold requests between the two halves
	lspc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.nonempty  (q_nonempty),
		.head      (q_head)
	);

	// run commands, thermal check, ramp and pattern; drive results
	lspc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.q_nonempty     (q_nonempty),
		.q_head         (q_head),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.led0_drive     (led0_drive),
		.led1_drive     (led1_drive),
		.thermal_active (thermal_active),
		.mode_now       (mode_now),
		.enabled_now    (enabled_now)
	);

endmodule

>>> hdl/lspc_checker.sv
module lspc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] led0_drive,
	input logic [7:0] led1_drive,
	input logic       thermal_active,
	input logic [1:0] mode_now,
	input logic       enabled_now
);
	logic [2:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// count requests still owed a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 3'd1;
		end else if (out_acc && !in_acc) begin
			pend_q <= pend_q - 3'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(led0_drive) && $stable(led1_drive)
			&& $stable(thermal_active) && $stable(mode_now) && $stable(enabled_now))
		else $error("stalled result changed");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> pend_q != 3'd0)
		else $error("result without a pending request");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd4)
		else $error("more requests in flight than the block can hold");

endmodule

bind led_strobe_pattern_controller_unit lspc_checker u_lspc_checker (.*);
